// File: hw/rtl/associative_key_value_table_macros.svh
// Assertion macros used by the key/value table controller.
`ifndef ASSOCIATIVE_KEY_VALUE_TABLE_MACROS_SVH
`define ASSOCIATIVE_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AKVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/akvt_pkg.sv
// Types and codes shared by the key/value table modules.
package akvt_pkg;

    // Request kinds; the fourth code is unused and answers as a miss.
    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_VIEW   = 2'd1,
        REQ_DELETE = 2'd2
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_DELETED  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // One stored pair.
    typedef struct packed {
        logic [30:0] key;
        logic [30:0] value;
    } t_entry;

    // One result word.
    typedef struct packed {
        t_status     status;
        logic [30:0] value_out;
        logic [6:0]  entry_count;
    } t_result;

endpackage

// File: hw/rtl/akvt_ram.sv
// Simple dual-port pair store: one write port, one registered read port.
module akvt_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 62
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/akvt_ctrl.sv
// Request sequencer: linear key search, update, append and delete with shift-down.
`include "associative_key_value_table_macros.svh"

module akvt_ctrl import akvt_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request side
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_req_type,
    input  logic [30:0]   i_key,
    input  logic [30:0]   i_value,
    // pair store
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output t_entry        o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  t_entry        i_mem_rdata,
    // result hand-off
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res
);

    localparam int XW = CW + 1;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        SHIFT,
        RESP
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_kind;
    logic [30:0]   r_key;
    logic [30:0]   r_value;
    logic [AW-1:0] r_cmp, n_cmp;
    logic [CW-1:0] r_count, n_count;
    t_result       r_res, n_res;

    logic          accept;
    logic [XW-1:0] cmp_x, cmp1, cmp2, cnt_x;
    logic          hit, last;
    logic [CW+6:0] cnt_wide;

    assign accept = i_in_valid && !o_in_stall;

    // in SCAN, r_cmp is the slot on the read port; in SHIFT, that port holds r_cmp + 1
    assign cmp_x = XW'(r_cmp);
    assign cmp1  = cmp_x + XW'(1);
    assign cmp2  = cmp_x + XW'(2);
    assign cnt_x = XW'(r_count);
    assign hit   = (cmp_x < cnt_x) && (i_mem_rdata.key == r_key);
    assign last  = (cmp1 >= cnt_x);

    // read address: next slot while scanning, the one after the next while shifting
    always_comb begin
        case (r_state)
            SCAN:    o_mem_raddr = cmp1[AW-1:0];
            SHIFT:   o_mem_raddr = cmp2[AW-1:0];
            default: o_mem_raddr = '0;
        endcase
    end

    // write port: update or append at the end of a scan, move a pair down while shifting
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cmp;
        o_mem_wdata = '{key: r_key, value: r_value};
        case (r_state)
            SCAN: begin
                if ((hit || last) && r_kind == REQ_SET) begin
                    if (hit) begin
                        o_mem_we = 1'b1;
                    end else if (r_count < CW'(CAPACITY)) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_count[AW-1:0];
                    end
                end
            end
            SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
            end
            default: ;
        endcase
    end

    // next state, slot pointer, pair count and result word
    always_comb begin
        n_state  = r_state;
        n_cmp    = r_cmp;
        n_count  = r_count;
        n_res    = r_res;
        cnt_wide = '0;
        case (r_state)
            IDLE: begin
                if (accept) begin
                    n_state = SCAN;
                    n_cmp   = '0;
                end
            end
            SCAN: begin
                if (hit || last) begin
                    n_state         = RESP;
                    n_res.status    = ST_MISSING;
                    n_res.value_out = '0;
                    case (r_kind)
                        REQ_SET: begin
                            if (hit) begin
                                n_res.status = ST_UPDATED;
                            end else if (r_count < CW'(CAPACITY)) begin
                                n_res.status = ST_INSERTED;
                                n_count      = r_count + CW'(1);
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        REQ_VIEW: begin
                            if (hit) begin
                                n_res.status    = ST_FOUND;
                                n_res.value_out = i_mem_rdata.value;
                            end
                        end
                        REQ_DELETE: begin
                            if (hit) begin
                                n_res.status = ST_DELETED;
                                if (last) begin
                                    n_count = r_count - CW'(1);
                                end else begin
                                    n_state = SHIFT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    n_cmp = r_cmp + AW'(1);
                end
            end
            SHIFT: begin
                // close the gap one pair per cycle
                if (cmp2 < cnt_x) begin
                    n_cmp = r_cmp + AW'(1);
                end else begin
                    n_state = RESP;
                    n_count = r_count - CW'(1);
                end
            end
            RESP: begin
                if (i_res_ready) begin
                    n_state = IDLE;
                end
            end
            default: n_state = IDLE;
        endcase
        cnt_wide          = {7'd0, n_count};
        n_res.entry_count = cnt_wide[6:0];
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_cmp   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_cmp   <= n_cmp;
            r_count <= n_count;
        end
        r_res <= n_res;
        if (accept) begin
            r_kind  <= i_req_type;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    assign o_in_stall  = (r_state != IDLE);
    assign o_res_valid = (r_state == RESP);
    assign o_res       = r_res;

    `AKVT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "pair count above capacity")
    `AKVT_ASSERT_IMP(a_write_state, i_clk, i_rst_n, o_mem_we, r_state == SCAN || r_state == SHIFT, "store written outside scan or shift")
    `AKVT_ASSERT_IMP(a_shift_range, i_clk, i_rst_n, r_state == SHIFT, cmp1 < cnt_x, "shift source beyond last pair")
    `AKVT_ASSERT_NEXT(a_handoff_idle, i_clk, i_rst_n, o_res_valid && i_res_ready, r_state == IDLE, "no return to idle after hand-off")
    `AKVT_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, accept, r_state == SCAN && r_cmp == '0, "scan does not start at the first slot")

endmodule

// File: hw/rtl/associative_key_value_table.sv
// A request scans one stored pair per cycle, in slot order, until it hits its key or reaches
// the last pair; the result word then waits in the controller until the output register
// takes it. A delete that hits first moves every later pair down one slot through the pair
// store. Requests are served one at a time: the next is taken only after the result has
// been handed to the output register, which an output stall can hold back.
// Reset (synchronous, active low) empties the table and control; the store is not cleared.
module associative_key_value_table import akvt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [30:0] i_key,
    input  logic [30:0] i_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [30:0] o_value_out,
    output logic [6:0]  o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          res_valid;
    logic          res_ready;
    t_result       res;

    logic          r_out_vld;
    t_result       r_out;

    akvt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .W     ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    akvt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output word register: takes a new result when empty or being drained
    assign res_ready = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out.status;
    assign o_value_out   = r_out.value_out;
    assign o_entry_count = r_out.entry_count;

endmodule

// File: tb/associative_key_value_table_test.sv
// Self-checking testbench for the associative key/value table: directed and random requests.
`timescale 1ns / 100ps

module associative_key_value_table_test;
    import akvt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int POOL_SIZE = 96;
    localparam int RANDOM_REQS = 1000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [30:0] WORD_MAX = 31'h7fff_ffff;

    // One request word plus a flag that holds it back until the table has answered everything
    typedef struct {
        logic [1:0]  kind;
        logic [30:0] key;
        logic [30:0] value;
        bit          drain;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [30:0] i_key;
    logic [30:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [30:0] o_value_out;
    logic [6:0]  o_entry_count;

    // Local copy of the table contents
    logic [30:0] kv_keys [TABLE_DEPTH];
    logic [30:0] kv_vals [TABLE_DEPTH];
    int          kv_count;

    t_request    pending_reqs [$];
    t_result     awaited_replies [$];
    logic [30:0] key_pool [POOL_SIZE];
    bit          req_taken;
    int          err_count;
    int          burst_left;
    int          gap_left;
    bit          stall_on;
    int          stall_left;

    associative_key_value_table #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_value_out  (o_value_out),
        .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the local table and return the reply word it should produce
    function automatic t_result serve_request(input logic [1:0] kind, input logic [30:0] k,
                                              input logic [30:0] v);
        t_result r;
        int      slot;
        int      i;
        slot = kv_count;
        // scan downwards so the first matching slot wins
        for (i = kv_count - 1; i >= 0; i--)
            if (kv_keys[i] == k)
                slot = i;
        r.status = ST_MISSING;
        r.value_out = '0;
        case (kind)
            REQ_SET: begin
                if (slot < kv_count) begin
                    kv_vals[slot] = v;
                    r.status = ST_UPDATED;
                end else if (kv_count < TABLE_DEPTH) begin
                    kv_keys[kv_count] = k;
                    kv_vals[kv_count] = v;
                    kv_count++;
                    r.status = ST_INSERTED;
                end else begin
                    r.status = ST_FULL;
                end
            end
            REQ_VIEW: begin
                if (slot < kv_count) begin
                    r.value_out = kv_vals[slot];
                    r.status = ST_FOUND;
                end
            end
            REQ_DELETE: begin
                if (slot < kv_count) begin
                    // close the gap, keeping insertion order
                    for (i = slot; i < kv_count - 1; i++) begin
                        kv_keys[i] = kv_keys[i + 1];
                        kv_vals[i] = kv_vals[i + 1];
                    end
                    kv_count--;
                    r.status = ST_DELETED;
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(kv_count);
        return r;
    endfunction

    // Random 31-bit word, leaning on the extremes now and then
    function automatic logic [30:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return WORD_MAX;
        return 31'($urandom);
    endfunction

    task automatic queue_req(input logic [1:0] kind, input logic [30:0] k, input logic [30:0] v,
                             input bit drain);
        t_request q;
        q.kind = kind;
        q.key = k;
        q.value = v;
        q.drain = drain;
        pending_reqs = {pending_reqs, q};
    endtask

    // Request driver: bursts of words with random gaps, fed from pending_reqs
    always @(negedge i_clk) begin : drive_requests
        t_request q;
        bit       next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || req_taken) begin
            req_taken = 1'b0;
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && awaited_replies.size() != 0)) begin
                q = pending_reqs.pop_front();
                i_req_type <= q.kind;
                i_key <= q.key;
                i_value <= q.value;
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // Reply stall pattern: short stalls, free runs of mixed length, some long clear stretches
    always @(negedge i_clk) begin : drive_stall
        bit next_stall;
        next_stall = stall_on;
        if (stall_left > 0) begin
            stall_left--;
        end else if (stall_on) begin
            next_stall = 1'b0;
            stall_left = ($urandom_range(0, 5) == 0) ? 300 : $urandom_range(1, 15);
        end else begin
            next_stall = ($urandom_range(0, 2) != 0);
            stall_left = $urandom_range(1, 8);
        end
        stall_on = next_stall;
        i_out_stall <= next_stall;
    end

    // Monitor: predict on each accepted request, check each accepted reply
    always @(posedge i_clk) begin : watch_ports
        t_result exp_r;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                awaited_replies = {awaited_replies, serve_request(i_req_type, i_key, i_value)};
                req_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected reply word: status %0d value_out %0d entry_count %0d",
                           o_status, o_value_out, o_entry_count);
                    err_count++;
                end else begin
                    exp_r = awaited_replies.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_status);
                        err_count++;
                    end
                    if (o_value_out !== exp_r.value_out) begin
                        $error("value_out: expected %0d, got %0d", exp_r.value_out,
                               o_value_out);
                        err_count++;
                    end
                    if (o_entry_count !== exp_r.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                               o_entry_count);
                        err_count++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int          made;
        int          mode;
        int          run_len;
        int          sel;
        int          fill_ptr;
        logic [1:0]  kind;
        logic [30:0] k;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_SET;
        i_key = '0;
        i_value = '0;
        i_out_stall = 1'b0;
        req_taken = 1'b0;
        err_count = 0;
        kv_count = 0;
        burst_left = 1;
        gap_left = 0;
        stall_on = 1'b0;
        stall_left = 20;
        fill_ptr = 0;

        // Directed: empty table, unused kind, zero and all-ones keys and values,
        // updates, deletes from the front and the back, miss after delete
        queue_req(REQ_VIEW, 31'd5, 31'd0, 1'b0);
        queue_req(REQ_DELETE, 31'd5, 31'd0, 1'b0);
        queue_req(REQ_UNUSED, 31'd5, 31'd9, 1'b0);
        queue_req(REQ_SET, 31'd0, 31'd0, 1'b0);
        queue_req(REQ_SET, WORD_MAX, WORD_MAX, 1'b0);
        queue_req(REQ_SET, 31'd1, 31'd1, 1'b0);
        queue_req(REQ_VIEW, 31'd0, 31'd7, 1'b0);
        queue_req(REQ_VIEW, WORD_MAX, 31'd0, 1'b0);
        queue_req(REQ_SET, WORD_MAX, 31'h2aaa_aaaa, 1'b0);
        queue_req(REQ_VIEW, WORD_MAX, 31'd0, 1'b0);
        queue_req(REQ_SET, 31'd0, 31'h5555_5555, 1'b0);
        queue_req(REQ_UNUSED, WORD_MAX, WORD_MAX, 1'b0);
        queue_req(REQ_VIEW, 31'd2, 31'd0, 1'b0);
        queue_req(REQ_DELETE, 31'd0, 31'd0, 1'b0);
        queue_req(REQ_VIEW, 31'd1, 31'd0, 1'b0);
        queue_req(REQ_VIEW, 31'd0, 31'd0, 1'b0);
        queue_req(REQ_DELETE, 31'd1, WORD_MAX, 1'b0);
        queue_req(REQ_VIEW, WORD_MAX, 31'd0, 1'b0);
        queue_req(REQ_DELETE, WORD_MAX, 31'd0, 1'b0);
        queue_req(REQ_DELETE, WORD_MAX, 31'd0, 1'b0);
        queue_req(REQ_SET, 31'h1234_5678, 31'h0765_4321, 1'b0);
        queue_req(REQ_VIEW, 31'h1234_5678, 31'd0, 1'b0);

        // Key pool small enough to hit often and large enough to overflow the table
        key_pool[0] = '0;
        key_pool[1] = WORD_MAX;
        key_pool[2] = 31'd1;
        for (int p = 3; p < POOL_SIZE; p++)
            key_pool[p] = 31'($urandom);

        // Random: runs that fill, churn or drain the table
        made = 0;
        while (made < RANDOM_REQS) begin
            mode = $urandom_range(0, 9);
            run_len = $urandom_range(20, 150);
            for (int n = 0; n < run_len && made < RANDOM_REQS; n++) begin
                sel = $urandom_range(0, 99);
                if (mode < 4)
                    kind = (sel < 80) ? REQ_SET : (sel < 95) ? REQ_VIEW : REQ_DELETE;
                else if (mode < 7)
                    kind = (sel < 35) ? REQ_SET : (sel < 70) ? REQ_VIEW : REQ_DELETE;
                else
                    kind = (sel < 15) ? REQ_SET : (sel < 45) ? REQ_VIEW : REQ_DELETE;
                if ($urandom_range(0, 24) == 0)
                    kind = REQ_UNUSED;
                sel = $urandom_range(0, 99);
                if (sel < 5) begin
                    k = 31'($urandom);
                end else if (mode < 4 && sel < 75) begin
                    // walk the pool so filling meets fresh keys
                    k = key_pool[fill_ptr];
                    fill_ptr = (fill_ptr + 1) % POOL_SIZE;
                end else begin
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                queue_req(kind, k, pick_word(), (made == 0) || ($urandom_range(0, 249) == 0));
                made++;
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (2 * TABLE_DEPTH + 10) @(posedge i_clk);

        if (err_count == 0 && awaited_replies.size() == 0) begin
            $display("associative_key_value_table_test: done, clean");
        end else begin
            $display("associative_key_value_table_test: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("associative_key_value_table_test: done, errors");
        $finish;
    end

endmodule
